[hdl/psrct_pkg.sv]
// ----------------------------------------------------------------------------
// psrct_pkg
// Shared widths, result codes and the controller-to-datapath command word
// for the per-source request counter table.
// ----------------------------------------------------------------------------
package psrct_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int PROTO_W  = 2;
  localparam int ADDR_W   = 32;
  localparam int KEY_W    = PROTO_W + ADDR_W;
  localparam int DELTA_W  = 8;
  localparam int OUT_W    = 16;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 16;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  localparam logic signed [LIMIT_W-1:0] LIMIT_RESET = -16'sd16;

  // result codes
  localparam logic [STATUS_W-1:0] ST_KEPT_POS  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REM_ZERO  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REM_LIMIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_KEPT_NEG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic load;     // capture the incoming word
    logic compare;  // key compare against every entry
    logic select;   // pick entry, read its count
    logic update;   // write back and present the result
  } psrct_cmd_t;

endpackage

[hdl/psrct_ctrl.sv]
// ----------------------------------------------------------------------------
// psrct_ctrl
// Sequencer: steps one word through compare, select and update.
// ----------------------------------------------------------------------------
module psrct_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output psrct_pkg::psrct_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.select  = (state_r == S_SEL);
  assign cmd.update  = (state_r == S_UPD);

endmodule

[hdl/psrct_dp.sv]
// ----------------------------------------------------------------------------
// psrct_dp
// Datapath: key store with parallel compare, count memory, lowest-index
// pick, saturating update and the result register.
// ----------------------------------------------------------------------------
module psrct_dp #(
  parameter int ENTRIES    = psrct_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = psrct_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  psrct_pkg::psrct_cmd_t                  cmd,
  input  logic [psrct_pkg::PROTO_W-1:0]          in_proto_class,
  input  logic [psrct_pkg::ADDR_W-1:0]           in_source_addr,
  input  logic signed [psrct_pkg::DELTA_W-1:0]   in_delta,
  input  logic                                   cfg_wr_en,
  input  logic signed [psrct_pkg::LIMIT_W-1:0]   cfg_wr_data,
  output logic                                   out_valid,
  output logic signed [psrct_pkg::OUT_W-1:0]     out_new_count,
  output logic [psrct_pkg::STATUS_W-1:0]         out_status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CW    = COUNT_BITS;
  localparam int WW    = (COUNT_BITS > psrct_pkg::OUT_W) ? COUNT_BITS : psrct_pkg::OUT_W;

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [psrct_pkg::LIMIT_W-1:0] low_limit_r;

  logic [psrct_pkg::KEY_W-1:0]          key_in_r;
  logic signed [psrct_pkg::DELTA_W-1:0] delta_r;

  logic [ENTRIES-1:0]          valid_r;
  logic [psrct_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic signed [CW-1:0]        cnt_mem [ENTRIES];

  logic [ENTRIES-1:0] hit_vec_r;
  logic [ENTRIES-1:0] free_vec_r;

  logic [IDX_W-1:0]     idx_r;
  logic                 hit_r;
  logic                 free_r;
  logic signed [CW-1:0] cnt_rd_r;

  logic                                out_valid_r;
  logic signed [psrct_pkg::OUT_W-1:0]  out_cnt_r;
  logic [psrct_pkg::STATUS_W-1:0]      out_status_r;

  // lowest-index pick
  logic [ENTRIES-1:0] hit_low;
  logic [ENTRIES-1:0] free_low;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;

  always_comb begin
    hit_low  = hit_vec_r & (~hit_vec_r + ENTRIES'(1));
    free_low = free_vec_r & (~free_vec_r + ENTRIES'(1));
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_low[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (free_low[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  // saturating update and keep/remove decision
  logic signed [CW:0]     sum;
  logic signed [CW-1:0]   upd_cnt;
  logic signed [CW-1:0]   res_cnt;
  logic signed [WW-1:0]   res_w;
  logic signed [WW-1:0]   lim_w;
  logic [psrct_pkg::STATUS_W-1:0]     res_status;
  logic                               keep;
  logic signed [psrct_pkg::OUT_W-1:0] res_out;

  always_comb begin
    sum = $signed({cnt_rd_r[CW-1], cnt_rd_r}) + (CW+1)'(delta_r);
    if (sum[CW] != sum[CW-1]) begin
      upd_cnt = sum[CW] ? CNT_MIN : CNT_MAX;
    end else begin
      upd_cnt = $signed(sum[CW-1:0]);
    end
    lim_w      = WW'(low_limit_r);
    keep       = 1'b1;
    res_cnt    = '0;
    res_status = psrct_pkg::ST_FULL;
    if (hit_r) begin
      res_cnt = upd_cnt;
      if (upd_cnt > 0) begin
        res_status = psrct_pkg::ST_KEPT_POS;
      end else if (upd_cnt == 0) begin
        res_status = psrct_pkg::ST_REM_ZERO;
        keep       = 1'b0;
      end else if (WW'(upd_cnt) < lim_w) begin
        res_status = psrct_pkg::ST_REM_LIMIT;
        keep       = 1'b0;
      end else begin
        res_status = psrct_pkg::ST_KEPT_NEG;
      end
    end else if (free_r) begin
      res_cnt    = CW'(delta_r);
      res_status = psrct_pkg::ST_INSERTED;
    end
    res_w = WW'(res_cnt);
    if (res_w > WW'(psrct_pkg::OUT_MAX)) begin
      res_out = psrct_pkg::OUT_W'(psrct_pkg::OUT_MAX);
    end else if (res_w < WW'(psrct_pkg::OUT_MIN)) begin
      res_out = psrct_pkg::OUT_W'(psrct_pkg::OUT_MIN);
    end else begin
      res_out = res_w[psrct_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r <= psrct_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      low_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_in_r <= {in_proto_class, in_source_addr};
      delta_r  <= in_delta;
    end
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec_r[i] <= valid_r[i] && (key_mem[i] == key_in_r);
      end
      free_vec_r <= ~valid_r;
    end
    if (cmd.select) begin
      hit_r    <= |hit_vec_r;
      free_r   <= |free_vec_r;
      idx_r    <= (|hit_vec_r) ? hit_idx : free_idx;
      cnt_rd_r <= cnt_mem[hit_idx];
    end
  end

  // count memory write port
  always_ff @(posedge clk) begin
    if (cmd.update && (hit_r || free_r)) begin
      cnt_mem[idx_r] <= res_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !hit_r && free_r) begin
      key_mem[idx_r] <= key_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.update && (hit_r || free_r)) begin
      valid_r[idx_r] <= hit_r ? keep : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_cnt_r    <= res_out;
      out_status_r <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_count = out_cnt_r;
  assign out_status    = out_status_r;

endmodule

[hdl/per_source_request_counter_table_top.sv]
// ----------------------------------------------------------------------------
// per_source_request_counter_table_top
// Counter table keyed by protocol class and IPv4 source, one result per word.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. busy then stays high
// through key compare against all entries, lowest-index pick with count
// memory read, and saturating update with write back; then the result is on
// out_new_count/out_status with out_valid high for the single cycle that
// follows, when busy is low again. low_limit resets to -16. The result cannot
// be stalled; the receiver must take it in that cycle. The user must write
// low_limit via cfg_wr_en/cfg_wr_data only while busy is low (not enforced).
module per_source_request_counter_table_top #(
  parameter int ENTRIES    = psrct_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = psrct_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [psrct_pkg::PROTO_W-1:0]        in_proto_class,
  input  logic [psrct_pkg::ADDR_W-1:0]         in_source_addr,
  input  logic signed [psrct_pkg::DELTA_W-1:0] in_delta,
  input  logic                                 cfg_wr_en,
  input  logic signed [psrct_pkg::LIMIT_W-1:0] cfg_wr_data,
  output logic                                 out_valid,
  output logic signed [psrct_pkg::OUT_W-1:0]   out_new_count,
  output logic [psrct_pkg::STATUS_W-1:0]       out_status
);

  psrct_pkg::psrct_cmd_t cmd;

  psrct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  psrct_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_proto_class (in_proto_class),
    .in_source_addr (in_source_addr),
    .in_delta       (in_delta),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_new_count  (out_new_count),
    .out_status     (out_status)
  );

endmodule

[hdl/psrct_chk.sv]
// ----------------------------------------------------------------------------
// psrct_chk
// Port-level checks on word timing and result codes of the counter table.
// ----------------------------------------------------------------------------
module psrct_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [psrct_pkg::OUT_W-1:0] out_new_count,
  input logic [psrct_pkg::STATUS_W-1:0]     out_status
);

  // every accepted word is followed by its result strobe
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("result strobe missing after accepted word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy ##1 busy ##1 busy)
    else $error("busy dropped during update");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe overlaps work");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == psrct_pkg::ST_FULL) |-> out_new_count == '0)
    else $error("full result with nonzero count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == psrct_pkg::ST_KEPT_POS) |-> out_new_count > 0)
    else $error("kept-positive result with count not above zero");

endmodule

bind per_source_request_counter_table_top psrct_chk u_chk (.*);

[bench/tb_per_source_request_counter_table_top.sv]
// ----------------------------------------------------------------------------
// tb_per_source_request_counter_table_top
// Self-checking bench for the per-source request counter table. A local
// mirror of the table predicts count and status for every accepted word.
// The run covers hand-written corner rows, a saturation run, a fill to full,
// and random phases over several low_limit settings with random sender gaps.
// ----------------------------------------------------------------------------
module tb_per_source_request_counter_table_top;

  typedef struct packed {
    logic signed [psrct_pkg::OUT_W-1:0] cnt;
    logic [psrct_pkg::STATUS_W-1:0]     st;
  } tally_t;

  typedef struct packed {
    logic [psrct_pkg::PROTO_W-1:0]        proto;
    logic [psrct_pkg::ADDR_W-1:0]         addr;
    logic signed [psrct_pkg::DELTA_W-1:0] delta;
    logic                                 known;
    logic signed [psrct_pkg::OUT_W-1:0]   cnt;
    logic [psrct_pkg::STATUS_W-1:0]       st;
  } step_row_t;

  localparam int STEP_N = 18;
  // known rows carry a hand-computed result, the rest go through the mirror
  localparam step_row_t STEP_ROWS [STEP_N] = '{
    '{2'd0, 32'h0000_0000,  8'sd127,  1'b1,  16'sd127, psrct_pkg::ST_INSERTED},
    '{2'd0, 32'h0000_0000,  8'sd127,  1'b0,  '0,       '0},
    '{2'd3, 32'hFFFF_FFFF, -8'sd128,  1'b1, -16'sd128, psrct_pkg::ST_INSERTED},
    '{2'd3, 32'hFFFF_FFFF,  8'sd1,    1'b0,  '0,       '0},
    '{2'd1, 32'h0A00_0001,  8'sd0,    1'b1,  16'sd0,   psrct_pkg::ST_INSERTED},
    '{2'd1, 32'h0A00_0001,  8'sd0,    1'b0,  '0,       '0},
    '{2'd2, 32'hC0A8_0001, -8'sd5,    1'b1, -16'sd5,   psrct_pkg::ST_INSERTED},
    '{2'd2, 32'hC0A8_0001, -8'sd11,   1'b0,  '0,       '0},
    '{2'd2, 32'hC0A8_0001, -8'sd1,    1'b0,  '0,       '0},
    '{2'd0, 32'h0000_0000, -8'sd128,  1'b0,  '0,       '0},
    '{2'd0, 32'h0000_0000, -8'sd126,  1'b0,  '0,       '0},
    '{2'd2, 32'h0000_0000,  8'sd1,    1'b1,  16'sd1,   psrct_pkg::ST_INSERTED},
    '{2'd1, 32'h0000_0000,  8'sd1,    1'b1,  16'sd1,   psrct_pkg::ST_INSERTED},
    '{2'd3, 32'h0000_0000,  8'sd1,    1'b1,  16'sd1,   psrct_pkg::ST_INSERTED},
    '{2'd2, 32'h0000_0000, -8'sd1,    1'b0,  '0,       '0},
    '{2'd3, 32'hFFFF_FFFF, -8'sd128,  1'b1, -16'sd128, psrct_pkg::ST_INSERTED},
    '{2'd3, 32'hFFFF_FFFF,  8'sd127,  1'b0,  '0,       '0},
    '{2'd3, 32'hFFFF_FFFF, -8'sd16,   1'b0,  '0,       '0}
  };

  localparam logic signed [psrct_pkg::LIMIT_W-1:0] PHASE_LIMITS [6] = '{
    -16'sd16, 16'sd0, -16'sd1, 16'sd1, 16'sh8000, 16'sh7FFF
  };

  logic                                 clk;
  logic                                 rst_n          = 1'b0;
  logic                                 start          = 1'b0;
  logic                                 busy;
  logic [psrct_pkg::PROTO_W-1:0]        in_proto_class = '0;
  logic [psrct_pkg::ADDR_W-1:0]         in_source_addr = '0;
  logic signed [psrct_pkg::DELTA_W-1:0] in_delta       = '0;
  logic                                 cfg_wr_en      = 1'b0;
  logic signed [psrct_pkg::LIMIT_W-1:0] cfg_wr_data    = '0;
  logic                                 out_valid;
  logic signed [psrct_pkg::OUT_W-1:0]   out_new_count;
  logic [psrct_pkg::STATUS_W-1:0]       out_status;

  // mirror of the table and the limit register
  logic                                 tbl_valid [psrct_pkg::ENTRIES_DEF];
  logic [psrct_pkg::KEY_W-1:0]          tbl_key   [psrct_pkg::ENTRIES_DEF];
  int                                   tbl_count [psrct_pkg::ENTRIES_DEF];
  logic signed [psrct_pkg::LIMIT_W-1:0] limit_mirror = psrct_pkg::LIMIT_RESET;

  tally_t counts_due [$];
  tally_t want_now;

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int limit_writes = 0;
  int status_seen [6];
  bit start_held   = 1'b0;
  bit idle_on      = 1'b0;

  per_source_request_counter_table_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_proto_class (in_proto_class),
    .in_source_addr (in_source_addr),
    .in_delta       (in_delta),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_new_count  (out_new_count),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("per_source_request_counter_table_top test failed");
    $finish;
  end

  function automatic int clamp_count(input int v);
    int hi;
    hi = (1 << (psrct_pkg::COUNT_BITS_DEF - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic tally_t apply_delta(input logic [psrct_pkg::PROTO_W-1:0] proto,
                                         input logic [psrct_pkg::ADDR_W-1:0] addr,
                                         input logic signed [psrct_pkg::DELTA_W-1:0] delta);
    logic [psrct_pkg::KEY_W-1:0] key;
    int hit;
    int spare;
    int sum;
    tally_t res;
    key = {proto, addr};
    hit = -1;
    spare = -1;
    sum = 0;
    for (int i = 0; i < psrct_pkg::ENTRIES_DEF; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit >= 0) begin
      sum = clamp_count(tbl_count[hit] + int'(delta));
      tbl_count[hit] = sum;
      if (sum > 0) begin
        res.st = psrct_pkg::ST_KEPT_POS;
      end else if (sum == 0) begin
        res.st = psrct_pkg::ST_REM_ZERO;
        tbl_valid[hit] = 1'b0;
      end else if (sum < int'(limit_mirror)) begin
        res.st = psrct_pkg::ST_REM_LIMIT;
        tbl_valid[hit] = 1'b0;
      end else begin
        res.st = psrct_pkg::ST_KEPT_NEG;
      end
    end else if (spare >= 0) begin
      sum = clamp_count(int'(delta));
      tbl_valid[spare] = 1'b1;
      tbl_key[spare]   = key;
      tbl_count[spare] = sum;
      res.st = psrct_pkg::ST_INSERTED;
    end else begin
      sum = 0;
      res.st = psrct_pkg::ST_FULL;
    end
    // port is 16 bits whatever the stored count width
    if (sum > psrct_pkg::OUT_MAX) sum = psrct_pkg::OUT_MAX;
    else if (sum < psrct_pkg::OUT_MIN) sum = psrct_pkg::OUT_MIN;
    res.cnt = psrct_pkg::OUT_W'(sum);
    return res;
  endfunction

  function automatic int unsigned rand_gap();
    if (!idle_on || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // start stays high into the next word when gap is zero
  task automatic send_word(input logic [psrct_pkg::PROTO_W-1:0] proto,
                           input logic [psrct_pkg::ADDR_W-1:0] addr,
                           input logic signed [psrct_pkg::DELTA_W-1:0] delta,
                           input int unsigned gap);
    start          <= 1'b1;
    in_proto_class <= proto;
    in_source_addr <= addr;
    in_delta       <= delta;
    @(posedge clk);
    while (busy) @(posedge clk);
    counts_due.push_back(apply_delta(proto, addr, delta));
    words_sent++;
    start_held = (gap == 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    if (start_held) start <= 1'b0;
    start_held = 1'b0;
    while (counts_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_low_limit(input logic signed [psrct_pkg::LIMIT_W-1:0] value);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    limit_mirror = value;
    limit_writes++;
  endtask

  // with a positive limit every negative count is dropped, so this drains
  task automatic empty_table();
    for (int i = 0; i < psrct_pkg::ENTRIES_DEF; i++)
      while (tbl_valid[i])
        send_word(tbl_key[i][psrct_pkg::KEY_W-1:psrct_pkg::ADDR_W],
                  tbl_key[i][psrct_pkg::ADDR_W-1:0], -8'sd128, rand_gap());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (counts_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d/%0d with no word pending",
                                out_new_count, out_status));
      end else begin
        want_now = counts_due.pop_front();
        if (out_new_count !== want_now.cnt)
          flag_mismatch($sformatf("result %0d new_count %0d, want %0d",
                                  results_seen, out_new_count, want_now.cnt));
        if (out_status !== want_now.st)
          flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_seen, out_status, want_now.st));
      end
      if (out_status <= psrct_pkg::ST_FULL) status_seen[out_status]++;
      results_seen++;
    end
  end

  initial begin
    logic signed [psrct_pkg::LIMIT_W-1:0] lim;
    logic [psrct_pkg::KEY_W-1:0]          pool [64];
    logic [psrct_pkg::KEY_W-1:0]          key;
    logic signed [psrct_pkg::DELTA_W-1:0] delta;
    int                                   pool_n;

    for (int i = 0; i < psrct_pkg::ENTRIES_DEF; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = 0;
    end
    for (int i = 0; i < 6; i++) status_seen[i] = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corner rows, reset limit still in force
    for (int r = 0; r < STEP_N; r++) begin
      send_word(STEP_ROWS[r].proto, STEP_ROWS[r].addr, STEP_ROWS[r].delta, 0);
      if (STEP_ROWS[r].known)
        counts_due[counts_due.size() - 1] = '{STEP_ROWS[r].cnt, STEP_ROWS[r].st};
    end

    // walk one counter up into the top rail, another down into the bottom rail
    write_low_limit(16'sh8000);
    for (int k = 0; k < 520; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (k < 260) send_word(2'd1, 32'h7F00_0001, 8'sd127, rand_gap());
      else send_word(2'd1, 32'h7F00_0002, -8'sd128, rand_gap());
    end

    // fill every entry, then new keys must come back full
    write_low_limit(16'sh7FFF);
    empty_table();
    for (int k = 0; k < psrct_pkg::ENTRIES_DEF + 3; k++)
      send_word(psrct_pkg::PROTO_W'($urandom), $urandom, 8'sd1, rand_gap());
    send_word(tbl_key[5][psrct_pkg::KEY_W-1:psrct_pkg::ADDR_W],
              tbl_key[5][psrct_pkg::ADDR_W-1:0], 8'sd1, rand_gap());

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) lim = PHASE_LIMITS[ph];
      else if (ph == 6) lim = psrct_pkg::LIMIT_W'(-int'($urandom_range(1, 32767)));
      else lim = psrct_pkg::LIMIT_W'($urandom);
      write_low_limit(16'sh7FFF);
      empty_table();
      write_low_limit(lim);

      // a small set of hosts gets most of the traffic so counts move around zero
      pool_n = $urandom_range(24, 56);
      for (int i = 0; i < pool_n; i++) pool[i] = {psrct_pkg::PROTO_W'($urandom), $urandom};

      for (int k = 0; k < 40; k++) begin
        if (k % 20 == 0) idle_on = (ph != 7) && ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, pool_n - 1)];
        else key = {psrct_pkg::PROTO_W'($urandom), $urandom};
        case ($urandom_range(0, 9))
          0, 1, 2, 3: delta = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
          4, 5, 6:    delta = psrct_pkg::DELTA_W'(int'($urandom_range(0, 16)) - 8);
          default:    delta = psrct_pkg::DELTA_W'($urandom);
        endcase
        send_word(key[psrct_pkg::KEY_W-1:psrct_pkg::ADDR_W],
                  key[psrct_pkg::ADDR_W-1:0], delta, rand_gap());
      end
    end

    quiesce();
    repeat (12) @(posedge clk);

    $display("covered %0d words, %0d results, %0d low_limit writes",
             words_sent, results_seen, limit_writes);
    $display("kept+ %0d  zero %0d  below-limit %0d  kept- %0d  inserted %0d  full %0d",
             status_seen[psrct_pkg::ST_KEPT_POS], status_seen[psrct_pkg::ST_REM_ZERO],
             status_seen[psrct_pkg::ST_REM_LIMIT], status_seen[psrct_pkg::ST_KEPT_NEG],
             status_seen[psrct_pkg::ST_INSERTED], status_seen[psrct_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("per_source_request_counter_table_top test passed");
    end else begin
      $display("per_source_request_counter_table_top test failed");
    end
    $finish;
  end

endmodule
